// File: hw/rtl/tmrd_pkg.sv
// shared types and character constants for the terminal mouse report decoder
package tmrd_pkg;

   localparam int CODE_W  = 9;
   localparam int COORD_W = 10;
   localparam int VALUE_W = 16;
   localparam int BTN_W   = 6;

   localparam logic [CODE_W-1:0] CH_LBRACKET = CODE_W'(8'h5B);
   localparam logic [CODE_W-1:0] CH_LESS     = CODE_W'(8'h3C);
   localparam logic [CODE_W-1:0] CH_UPPER_M  = CODE_W'(8'h4D);
   localparam logic [CODE_W-1:0] CH_LOWER_M  = CODE_W'(8'h6D);
   localparam logic [CODE_W-1:0] CH_SEMI     = CODE_W'(8'h3B);
   localparam logic [CODE_W-1:0] CH_ZERO     = CODE_W'(8'h30);
   localparam logic [CODE_W-1:0] CH_NINE     = CODE_W'(8'h39);

   localparam logic [VALUE_W-1:0] VALUE_MAX  = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] X10_OFFSET = VALUE_W'(33);
   localparam logic [VALUE_W-1:0] DEC_OFFSET = VALUE_W'(1);

   localparam logic [1:0] BTN_LEFT  = 2'd0;
   localparam logic [1:0] BTN_RIGHT = 2'd2;
   localparam int         MOTION_BIT = 5;

   localparam logic CSR_SCREEN_COLUMNS = 1'b0;
   localparam logic CSR_PLAY_ROWS      = 1'b1;

   localparam logic [COORD_W-1:0] SCREEN_COLUMNS_RESET = COORD_W'(80);
   localparam logic [COORD_W-1:0] PLAY_ROWS_RESET      = COORD_W'(20);

   typedef enum logic [1:0] {
      FMT_UNKNOWN,
      FMT_SGR,
      FMT_X10,
      FMT_URXVT
   } fmt_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last;
   } req_type;

   typedef struct packed {
      logic               recognized;
      logic               in_area;
      logic [COORD_W-1:0] pointer_col;
      logic [COORD_W-1:0] pointer_row;
      logic               place_request;
      logic               attack_request;
   } rsp_type;

   // parsed report handed from the parser to the evaluator
   typedef struct packed {
      logic               final_seen;
      fmt_type            fmt;
      logic [BTN_W-1:0]   button;
      logic [VALUE_W-1:0] col;
      logic [VALUE_W-1:0] row;
      logic               press;
   } report_type;

endpackage

// File: hw/rtl/tmrd_fifo.sv
// small register queue used between the decoder stages and at the output
module tmrd_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: hw/rtl/tmrd_parser.sv
// front end: takes report bytes one per cycle while accept is high and builds the parsed report
module tmrd_parser #(
   parameter int MAX_REPORT_LEN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  tmrd_pkg::req_type   req,
   output logic                report_push,
   output tmrd_pkg::report_type report
);

   localparam int CW = $clog2(MAX_REPORT_LEN + 1);

   tmrd_pkg::fmt_type               fmt_ff, fmt_in;
   logic [1:0]                      phase_ff, phase_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [tmrd_pkg::VALUE_W-1:0]    btn_ff, btn_in;
   logic [tmrd_pkg::VALUE_W-1:0]    col_ff, col_in;
   logic [tmrd_pkg::VALUE_W-1:0]    row_ff, row_in;
   logic                            digit_ff, digit_in;
   logic                            fail_ff, fail_in;
   logic                            final_ff, final_in;
   logic                            press_ff, press_in;

   logic [tmrd_pkg::CODE_W-1:0]     code;
   logic                            is_digit;
   logic                            do_numeric;
   logic [tmrd_pkg::VALUE_W-1:0]    acc_sel;
   logic [tmrd_pkg::VALUE_W+3:0]    acc_sum;
   logic [tmrd_pkg::VALUE_W-1:0]    acc_sat;

   assign code     = req.code;
   assign is_digit = code inside {[tmrd_pkg::CH_ZERO : tmrd_pkg::CH_NINE]};

   // one decimal digit step: v * 10 + d, saturating
   always_comb begin
      case (phase_ff)
         2'd0:    acc_sel = btn_ff;
         2'd1:    acc_sel = col_ff;
         default: acc_sel = row_ff;
      endcase
      acc_sum = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
              + (tmrd_pkg::VALUE_W + 4)'(code - tmrd_pkg::CH_ZERO);
      acc_sat = (acc_sum > (tmrd_pkg::VALUE_W + 4)'(tmrd_pkg::VALUE_MAX))
              ? tmrd_pkg::VALUE_MAX : acc_sum[tmrd_pkg::VALUE_W-1:0];
   end

   always_comb begin
      fmt_in     = fmt_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      btn_in     = btn_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      digit_in   = digit_ff;
      fail_in    = fail_ff;
      final_in   = final_ff;
      press_in   = press_ff;
      do_numeric = 1'b0;

      if (accept && (count_ff < CW'(MAX_REPORT_LEN))) begin
         count_in = count_ff + 1'b1;
         if (!fail_ff && !final_ff) begin
            if (count_ff == CW'(0)) begin
               if (code != tmrd_pkg::CH_LBRACKET) begin
                  fail_in = 1'b1;
               end
            end else if (count_ff == CW'(1)) begin
               if (code == tmrd_pkg::CH_LESS) begin
                  fmt_in = tmrd_pkg::FMT_SGR;
               end else if (code == tmrd_pkg::CH_UPPER_M) begin
                  fmt_in = tmrd_pkg::FMT_X10;
               end else begin
                  fmt_in     = tmrd_pkg::FMT_URXVT;
                  do_numeric = 1'b1;
               end
            end else if (fmt_ff == tmrd_pkg::FMT_X10) begin
               // raw bytes: button, column, row
               if (count_ff == CW'(2)) begin
                  btn_in = tmrd_pkg::VALUE_W'(code);
               end else if (count_ff == CW'(3)) begin
                  col_in = tmrd_pkg::VALUE_W'(code);
               end else begin
                  row_in   = tmrd_pkg::VALUE_W'(code);
                  final_in = 1'b1;
               end
            end else begin
               do_numeric = 1'b1;
            end
         end
      end

      if (do_numeric) begin
         if (is_digit) begin
            case (phase_ff)
               2'd0:    btn_in = acc_sat;
               2'd1:    col_in = acc_sat;
               default: row_in = acc_sat;
            endcase
            digit_in = 1'b1;
         end else if (!digit_ff) begin
            fail_in = 1'b1;
         end else if (phase_ff != 2'd2) begin
            if (code == tmrd_pkg::CH_SEMI) begin
               phase_in = phase_ff + 1'b1;
               digit_in = 1'b0;
            end else begin
               fail_in = 1'b1;
            end
         end else if (code == tmrd_pkg::CH_UPPER_M ||
                      (code == tmrd_pkg::CH_LOWER_M && fmt_in == tmrd_pkg::FMT_SGR)) begin
            final_in = 1'b1;
            press_in = (code == tmrd_pkg::CH_UPPER_M);
         end else begin
            fail_in = 1'b1;
         end
      end

      report_push       = accept && req.last;
      report.final_seen = final_in;
      report.fmt        = fmt_in;
      report.button     = btn_in[tmrd_pkg::BTN_W-1:0];
      report.col        = col_in;
      report.row        = row_in;
      report.press      = press_in;

      // start over after each final byte
      if (report_push) begin
         fmt_in   = tmrd_pkg::FMT_UNKNOWN;
         phase_in = '0;
         count_in = '0;
         btn_in   = '0;
         col_in   = '0;
         row_in   = '0;
         digit_in = 1'b0;
         fail_in  = 1'b0;
         final_in = 1'b0;
         press_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= tmrd_pkg::FMT_UNKNOWN;
         phase_ff <= '0;
         count_ff <= '0;
         btn_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         digit_ff <= 1'b0;
         fail_ff  <= 1'b0;
         final_ff <= 1'b0;
         press_ff <= 1'b0;
      end else begin
         fmt_ff   <= fmt_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         btn_ff   <= btn_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         digit_ff <= digit_in;
         fail_ff  <= fail_in;
         final_ff <= final_in;
         press_ff <= press_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_REPORT_LEN))
      else $error("byte count ran past the report limit");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("field phase out of range");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req.last) |=> (count_ff == '0 && !final_ff && !fail_ff))
      else $error("parse state not cleared after final byte");

endmodule

// File: hw/rtl/tmrd_eval.sv
// back end: turns a parsed report into area and button decisions
module tmrd_eval (
   input  logic                         clock,
   input  logic                         reset,
   input  tmrd_pkg::report_type         report,
   input  logic [tmrd_pkg::COORD_W-1:0] screen_columns,
   input  logic [tmrd_pkg::COORD_W-1:0] play_rows,
   input  logic                         valid,
   output tmrd_pkg::rsp_type            rsp
);

   logic [tmrd_pkg::VALUE_W-1:0] offset;
   logic [tmrd_pkg::VALUE_W-1:0] col_rel, row_rel;
   logic                         in_box;
   logic [1:0]                   base;
   logic                         motion;
   logic                         place, attack;

   always_comb begin
      offset  = (report.fmt == tmrd_pkg::FMT_X10) ? tmrd_pkg::X10_OFFSET
                                                  : tmrd_pkg::DEC_OFFSET;
      col_rel = report.col - offset;
      row_rel = report.row - offset;
      in_box  = report.final_seen
             && (report.col >= offset) && (report.row >= offset)
             && (col_rel < tmrd_pkg::VALUE_W'(screen_columns))
             && (row_rel < tmrd_pkg::VALUE_W'(play_rows));
      base    = report.button[1:0];
      motion  = report.button[tmrd_pkg::MOTION_BIT];
      place   = 1'b0;
      attack  = 1'b0;
      if (report.fmt == tmrd_pkg::FMT_SGR) begin
         // motion only counts for left and right
         if (!motion || (base inside {tmrd_pkg::BTN_LEFT, tmrd_pkg::BTN_RIGHT})) begin
            if (report.press && base == tmrd_pkg::BTN_RIGHT) begin
               place = 1'b1;
            end else if (base == tmrd_pkg::BTN_LEFT) begin
               attack = 1'b1;
            end
         end
      end else begin
         place  = (base == tmrd_pkg::BTN_RIGHT);
         attack = (base == tmrd_pkg::BTN_LEFT);
      end

      rsp.recognized     = report.final_seen;
      rsp.in_area        = in_box;
      rsp.pointer_col    = in_box ? col_rel[tmrd_pkg::COORD_W-1:0] : '0;
      rsp.pointer_row    = in_box ? row_rel[tmrd_pkg::COORD_W-1:0] : '0;
      rsp.place_request  = in_box && place;
      rsp.attack_request = in_box && attack;
   end

   assert property (@(posedge clock) disable iff (reset)
      (valid && rsp.in_area) |-> rsp.recognized)
      else $error("in_area without a recognized report");

   assert property (@(posedge clock) disable iff (reset)
      valid |-> !(rsp.place_request && rsp.attack_request))
      else $error("place and attack both requested");

endmodule

// File: hw/rtl/terminal_mouse_report_decoder_top.sv
// top level of the terminal mouse report decoder
// a result word passes through the report queue and then the output queue before it can be popped
// throughput: one byte per cycle while req_full is low; parser feeds a report queue, evaluator an output queue
// full rises only when the report queue is full, so bytes keep flowing while results wait
// reset (synchronous): clears parse state and both queues, screen_columns 80, play_rows 20
module terminal_mouse_report_decoder_top #(
   parameter int MAX_REPORT_LEN = 32,
   parameter int QUEUE_DEPTH    = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  tmrd_pkg::req_type            req_data,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output tmrd_pkg::rsp_type            rsp_data,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [tmrd_pkg::COORD_W-1:0] csr_wdata
);

   localparam int RPT_W = $bits(tmrd_pkg::report_type);
   localparam int RSP_W = $bits(tmrd_pkg::rsp_type);

   logic [tmrd_pkg::COORD_W-1:0] screen_columns_ff, play_rows_ff;
   logic                         accept;
   logic                         report_push;
   tmrd_pkg::report_type         report_wr, report_rd;
   logic                         rpt_full, rpt_empty;
   logic                         out_full;
   logic                         move;
   tmrd_pkg::rsp_type            rsp_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_columns_ff <= tmrd_pkg::SCREEN_COLUMNS_RESET;
         play_rows_ff      <= tmrd_pkg::PLAY_ROWS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tmrd_pkg::CSR_SCREEN_COLUMNS: screen_columns_ff <= csr_wdata;
            tmrd_pkg::CSR_PLAY_ROWS:      play_rows_ff      <= csr_wdata;
            default:                      ;
         endcase
      end
   end

   assign req_full = rpt_full;
   assign accept   = req_push && !req_full;
   assign move     = !rpt_empty && !out_full;

   tmrd_parser #(
      .MAX_REPORT_LEN(MAX_REPORT_LEN)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .report_push (report_push),
      .report      (report_wr)
   );

   tmrd_fifo #(
      .WIDTH(RPT_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_report_q (
      .clock (clock),
      .reset (reset),
      .push  (report_push),
      .wdata (report_wr),
      .full  (rpt_full),
      .pop   (move),
      .rdata (report_rd),
      .empty (rpt_empty)
   );

   tmrd_eval u_eval (
      .clock          (clock),
      .reset          (reset),
      .report         (report_rd),
      .screen_columns (screen_columns_ff),
      .play_rows      (play_rows_ff),
      .valid          (move),
      .rsp            (rsp_wr)
   );

   tmrd_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (move),
      .wdata (rsp_wr),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// File: test/tb.sv
// self-checking testbench for the terminal mouse report decoder
`timescale 1ns / 1ps

module tb;
   import tmrd_pkg::*;

   localparam int REPORT_LEN_MAX = 32;
   localparam int SETTLE_CYCLES  = 8;
   localparam int QUIET_LIMIT    = 4000;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   req_type             req_data;
   logic                rsp_empty;
   logic                rsp_pop;
   rsp_type             rsp_data;
   logic                csr_write;
   logic                csr_index;
   logic [COORD_W-1:0]  csr_wdata;

   terminal_mouse_report_decoder_top #(
      .MAX_REPORT_LEN(REPORT_LEN_MAX)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder model state
   logic [COORD_W-1:0] col_limit;
   logic [COORD_W-1:0] row_limit;
   fmt_type            fmt_kind;
   int unsigned        field_sel;
   int unsigned        bytes_taken;
   logic [VALUE_W-1:0] btn_acc;
   logic [VALUE_W-1:0] col_acc;
   logic [VALUE_W-1:0] row_acc;
   logic               have_digit;
   logic               bad_syntax;
   logic               got_final;
   logic               press_end;

   rsp_type            expected_reports[$];
   logic [CODE_W-1:0]  frame_codes[$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int error_count;
   int items_sent;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   function automatic void clear_decoder();
      fmt_kind    = FMT_UNKNOWN;
      field_sel   = 0;
      bytes_taken = 0;
      btn_acc     = '0;
      col_acc     = '0;
      row_acc     = '0;
      have_digit  = 1'b0;
      bad_syntax  = 1'b0;
      got_final   = 1'b0;
      press_end   = 1'b0;
   endfunction

   function automatic void append_code(logic [CODE_W-1:0] c);
      frame_codes.insert(frame_codes.size(), c);
   endfunction

   function automatic logic [VALUE_W-1:0] add_digit(logic [VALUE_W-1:0] v,
                                                    logic [CODE_W-1:0] c);
      int unsigned n;
      n = int'(v) * 10 + int'(c - CH_ZERO);
      return (n > VALUE_MAX) ? VALUE_MAX : VALUE_W'(n);
   endfunction

   function automatic void take_numeric(logic [CODE_W-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (field_sel == 0) btn_acc = add_digit(btn_acc, c);
         else if (field_sel == 1) col_acc = add_digit(col_acc, c);
         else row_acc = add_digit(row_acc, c);
         have_digit = 1'b1;
      end else if (!have_digit) begin
         bad_syntax = 1'b1;
      end else if (field_sel < 2) begin
         if (c == CH_SEMI) begin
            field_sel++;
            have_digit = 1'b0;
         end else begin
            bad_syntax = 1'b1;
         end
      end else if (c == CH_UPPER_M || (c == CH_LOWER_M && fmt_kind == FMT_SGR)) begin
         got_final = 1'b1;
         press_end = (c == CH_UPPER_M);
      end else begin
         bad_syntax = 1'b1;
      end
   endfunction

   // advance the model by one accepted word, queue a report on the last one
   function automatic void decode_byte(logic [CODE_W-1:0] c, logic l);
      int unsigned        pos;
      rsp_type            r;
      logic [VALUE_W-1:0] off;
      logic [1:0]         base;
      if (bytes_taken < REPORT_LEN_MAX) begin
         pos = bytes_taken;
         bytes_taken++;
         if (!bad_syntax && !got_final) begin
            if (pos == 0) begin
               if (c != CH_LBRACKET) bad_syntax = 1'b1;
            end else if (pos == 1) begin
               if (c == CH_LESS) begin
                  fmt_kind = FMT_SGR;
               end else if (c == CH_UPPER_M) begin
                  fmt_kind = FMT_X10;
               end else begin
                  fmt_kind = FMT_URXVT;
                  take_numeric(c);
               end
            end else if (fmt_kind == FMT_X10) begin
               if (pos == 2) btn_acc = VALUE_W'(c);
               else if (pos == 3) col_acc = VALUE_W'(c);
               else begin
                  row_acc = VALUE_W'(c);
                  got_final = 1'b1;
               end
            end else begin
               take_numeric(c);
            end
         end
      end
      if (l) begin
         r = '0;
         r.recognized = got_final;
         if (got_final) begin
            off = (fmt_kind == FMT_X10) ? X10_OFFSET : DEC_OFFSET;
            if (col_acc >= off && row_acc >= off && col_acc - off < col_limit
                && row_acc - off < row_limit) begin
               r.in_area     = 1'b1;
               r.pointer_col = COORD_W'(col_acc - off);
               r.pointer_row = COORD_W'(row_acc - off);
               base = btn_acc[1:0];
               if (fmt_kind == FMT_SGR) begin
                  // motion only counts for left and right
                  if (!btn_acc[MOTION_BIT] || base == BTN_LEFT || base == BTN_RIGHT) begin
                     if (press_end && base == BTN_RIGHT) r.place_request = 1'b1;
                     else if (base == BTN_LEFT) r.attack_request = 1'b1;
                  end
               end else begin
                  if (base == BTN_RIGHT) r.place_request = 1'b1;
                  else if (base == BTN_LEFT) r.attack_request = 1'b1;
               end
            end
         end
         expected_reports.insert(expected_reports.size(), r);
         clear_decoder();
      end
   endfunction

   function automatic string show_rsp(rsp_type r);
      return $sformatf("rec=%0b area=%0b col=%0d row=%0d place=%0b attack=%0b",
                       r.recognized, r.in_area, r.pointer_col, r.pointer_row,
                       r.place_request, r.attack_request);
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_reports.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected word: %s", show_rsp(rsp_data));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_data.recognized !== want.recognized
                || rsp_data.in_area !== want.in_area
                || rsp_data.pointer_col !== want.pointer_col
                || rsp_data.pointer_row !== want.pointer_row
                || rsp_data.place_request !== want.place_request
                || rsp_data.attack_request !== want.attack_request) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %s, got %s", show_rsp(want),
                           show_rsp(rsp_data));
            end
         end
      end
   end

   // receiver with random stalls and a counted hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_pop <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(logic [CODE_W-1:0] c, logic l);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{code: c, last: l};
      do @(posedge clock); while (req_full);
      decode_byte(c, l);
      items_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_codes.size(); i++)
         send_word(frame_codes[i], i == frame_codes.size() - 1);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [COORD_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_SCREEN_COLUMNS) col_limit = value;
      else row_limit = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_text(string s);
      frame_codes.delete();
      for (int i = 0; i < s.len(); i++) append_code({1'b0, s[i]});
   endtask

   task automatic append_decimal(int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 3)) append_code(CH_ZERO);
      for (int i = 0; i < s.len(); i++) append_code({1'b0, s[i]});
   endtask

   function automatic int unsigned pick_coord(logic [COORD_W-1:0] limit);
      case ($urandom_range(9))
         0: return 0;
         1: return limit;
         2: return int'(limit) + 1;
         3: return $urandom_range(70000);
         default: return $urandom_range(1, int'(limit) + 1);
      endcase
   endfunction

   function automatic int unsigned pick_button();
      if ($urandom_range(9) == 0) return $urandom_range(70000);
      return $urandom_range(3) + ($urandom_range(1) << MOTION_BIT)
             + (($urandom_range(3) == 0) ? 64 : 0);
   endfunction

   function automatic logic [CODE_W-1:0] pick_x10_coord(logic [COORD_W-1:0] limit);
      int unsigned v;
      case ($urandom_range(5))
         0: v = $urandom_range(511);
         1: v = X10_OFFSET - 1 + limit;
         2: v = X10_OFFSET + limit;
         3: v = X10_OFFSET - 1;
         default: v = X10_OFFSET + $urandom_range(limit);
      endcase
      if (v > 511) v = 511;
      return CODE_W'(v);
   endfunction

   task automatic build_decimal_report(fmt_type f);
      frame_codes.delete();
      append_code(CH_LBRACKET);
      if (f == FMT_SGR) append_code(CH_LESS);
      append_decimal(pick_button());
      append_code(CH_SEMI);
      append_decimal(pick_coord(col_limit));
      append_code(CH_SEMI);
      append_decimal(pick_coord(row_limit));
      if (f == FMT_SGR)
         append_code($urandom_range(1) ? CH_UPPER_M : CH_LOWER_M);
      else
         append_code(($urandom_range(9) == 0) ? CH_LOWER_M : CH_UPPER_M);
   endtask

   task automatic build_x10_report();
      load_text("[M");
      if ($urandom_range(3) == 0)
         append_code(CODE_W'($urandom_range(511)));
      else
         append_code(CODE_W'(X10_OFFSET - 1 + $urandom_range(3)));
      append_code(pick_x10_coord(col_limit));
      append_code(pick_x10_coord(row_limit));
   endtask

   task automatic break_frame();
      int unsigned k;
      case ($urandom_range(4))
         0: begin
            // cut off before the terminator
            k = $urandom_range(1, frame_codes.size() - 1);
            while (frame_codes.size() > k) frame_codes.delete(frame_codes.size() - 1);
         end
         1: frame_codes[$urandom_range(frame_codes.size() - 1)] = CODE_W'($urandom_range(511));
         2: repeat ($urandom_range(1, 6)) append_code(CODE_W'($urandom_range(511)));
         3: frame_codes[0] = CODE_W'($urandom_range(511));
         // pad with zeros so the report may run past the length cap
         default: repeat ($urandom_range(20, 36)) frame_codes.insert(2, CH_ZERO);
      endcase
   endtask

   task automatic send_random_report();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 88) begin
         if (sel < 33) build_decimal_report(FMT_SGR);
         else if (sel < 60) build_x10_report();
         else build_decimal_report(FMT_URXVT);
         if ($urandom_range(99) < 18) break_frame();
      end else begin
         frame_codes.delete();
         repeat ($urandom_range(1, 40)) append_code(CODE_W'($urandom_range(511)));
         if ($urandom_range(1)) frame_codes[0] = CH_LBRACKET;
      end
      send_frame();
   endtask

   task automatic run_random(int target);
      int start;
      start = items_sent;
      while (items_sent - start < target) send_random_report();
   endtask

   task automatic test_directed();
      // x10 right press at column 5, row 3
      load_text("[M");
      append_code(CODE_W'(X10_OFFSET - 1 + BTN_RIGHT));
      append_code(CODE_W'(X10_OFFSET + 5));
      append_code(CODE_W'(X10_OFFSET + 3));
      send_frame();
      // sgr left release at the origin
      load_text("[<0;1;1m");
      send_frame();
      // lone zero code: bad lead byte
      frame_codes.delete();
      append_code('0);
      send_frame();
      // all-ones code never matches a character
      load_text("[");
      append_code('1);
      send_frame();
      // urxvt right press on the last cell of the default area
      load_text("[2;80;20M");
      send_frame();
   endtask

   task automatic test_register_settings();
      wait_for_drain();
      write_reg(CSR_SCREEN_COLUMNS, '0);
      write_reg(CSR_PLAY_ROWS, '0);
      run_random(80);
      wait_for_drain();
      write_reg(CSR_SCREEN_COLUMNS, '1);
      write_reg(CSR_PLAY_ROWS, '1);
      run_random(80);
      wait_for_drain();
      write_reg(CSR_SCREEN_COLUMNS, COORD_W'(1));
      write_reg(CSR_PLAY_ROWS, COORD_W'(1));
      run_random(80);
      wait_for_drain();
      write_reg(CSR_SCREEN_COLUMNS, COORD_W'($urandom_range(2, 300)));
      write_reg(CSR_PLAY_ROWS, COORD_W'($urandom_range(2, 120)));
      run_random(80);
      wait_for_drain();
      write_reg(CSR_SCREEN_COLUMNS, SCREEN_COLUMNS_RESET);
      write_reg(CSR_PLAY_ROWS, PLAY_ROWS_RESET);
   endtask

   task automatic test_idle_phases();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(250);
      send_idle_pct = 84;
      run_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 84;
      run_random(250);
      send_idle_pct = 12;
      recv_stall_pct = 12;
      run_random(250);
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      build_x10_report();
      send_frame();
      // results pile up until the block stops taking words
      hold_left = 400;
      repeat (30) begin
         build_x10_report();
         send_frame();
      end
      wait_for_drain();
      run_random(60);
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_data       = '0;
      rsp_pop        = 1'b0;
      csr_write      = 1'b0;
      csr_index      = CSR_SCREEN_COLUMNS;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      error_count    = 0;
      items_sent     = 0;
      col_limit      = SCREEN_COLUMNS_RESET;
      row_limit      = PLAY_ROWS_RESET;
      clear_decoder();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_register_settings();
      test_idle_phases();
      test_backpressure();

      wait_for_drain();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
